// File: src/dssa_pkg.sv
package dssa_pkg;

	// Field widths of the request and response beats.
	localparam int unsigned WORD_W = 32;
	localparam int unsigned BYTE_W = 8;

	// Key derivation: replicated top seed byte, then a fixed number of
	// shift-and-conditional-XOR rounds.
	localparam int unsigned KEY_ROUNDS = 35;
	localparam logic [WORD_W-1:0] BYTE_REPLICATE = 32'h0101_0101;

	// Configuration register reset values.
	localparam logic [BYTE_W-1:0] LEN_RESET  = 8'd2;
	localparam logic [WORD_W-1:0] MASK_RESET = 32'h7FAD_EBFC;

	// Configuration register indexes.
	localparam logic [BYTE_W-1:0] CFG_SESSION_LEN = 8'd0;
	localparam logic [BYTE_W-1:0] CFG_KEY_MASK    = 8'd1;

	// Session identifiers.
	localparam logic [1:0] SESS_DEFAULT  = 2'd1;
	localparam logic [1:0] SESS_PROGRAM  = 2'd2;
	localparam logic [1:0] SESS_EXTENDED = 2'd3;

	// Security access subfunctions.
	localparam logic [BYTE_W-1:0] SUB_SEED_REQ = 8'd1;
	localparam logic [BYTE_W-1:0] SUB_SEND_KEY = 8'd2;

	typedef enum logic [1:0] {
		REQ_SESSION  = 2'd0,
		REQ_SECURITY = 2'd1,
		REQ_TICK     = 2'd2
	} req_type_t;

	typedef enum logic [1:0] {
		SVC_SESSION  = 2'd0,
		SVC_SECURITY = 2'd1,
		SVC_JUMP     = 2'd2
	} resp_service_t;

	typedef enum logic [1:0] {
		CODE_NONE        = 2'd0,
		CODE_BAD_FORMAT  = 2'd1,
		CODE_NOT_ACTIVE  = 2'd2,
		CODE_UNSUPPORTED = 2'd3
	} resp_code_t;

endpackage

// File: src/dssa_key_derive.sv
module dssa_key_derive
	import dssa_pkg::*;
(
	input  logic [WORD_W-1:0] seed,
	input  logic [WORD_W-1:0] mask,
	output logic [WORD_W-1:0] key
);

	logic [WORD_W-1:0] w;

	// Each round is a multiply by x modulo the polynomial given by the mask.
	always_comb begin
		w = seed[WORD_W-1 -: BYTE_W] * BYTE_REPLICATE;
		for (int unsigned i = 0; i < KEY_ROUNDS; i++) begin
			if (w[WORD_W-1]) begin
				w = {w[WORD_W-2:0], 1'b0} ^ mask;
			end else begin
				w = {w[WORD_W-2:0], 1'b0};
			end
		end
		key = w;
	end

endmodule

// File: src/diag_session_security_access.sv
// Diagnostic session control and seed/key security access responder.
//
// Requests arrive as beats on the input channel (in_valid, in_stall); one
// is taken at each rising edge where in_valid is high and in_stall is low.
// Session and security requests each produce exactly one response beat on
// the output channel (out_valid, out_stall); periodic ticks and the unused
// request type produce none. The configuration channel (cfg_valid,
// cfg_ready, cfg_index, cfg_data) is always ready and should only be
// written while the block is idle.
//
// A taken request waits in the request register; its response goes to the
// response register once that is free. One request per cycle is taken
// while out_stall is low: the request register, the decision logic with
// the key derivation and the response register form a single pass.
//
// When the receiver stalls, the response register holds its beat and the
// request register keeps the next one; in_stall rises only once both are
// full. Reset (arst_n low) returns the sessions to default, the security
// phase to idle, the stored seed to zero and the configuration registers
// to their reset values, and empties both registers.
module diag_session_security_access
	import dssa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,

	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        req_type,
	input  logic [BYTE_W-1:0] req_length,
	input  logic [BYTE_W-1:0] sub_function,
	input  logic [WORD_W-1:0] key_in,
	input  logic [WORD_W-1:0] random_seed,

	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        resp_service,
	output logic              resp_positive,
	output logic [1:0]        resp_code,
	output logic [BYTE_W-1:0] resp_session_echo,
	output logic [WORD_W-1:0] seed_out,

	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [BYTE_W-1:0] cfg_index,
	input  logic [WORD_W-1:0] cfg_data
);

	typedef enum logic [1:0] {
		PH_IDLE     = 2'd0,
		PH_ARMED    = 2'd1,
		PH_SEED     = 2'd2,
		PH_UNLOCKED = 2'd3
	} phase_t;

	// Configuration registers.
	logic [BYTE_W-1:0] session_len_q;
	logic [WORD_W-1:0] key_mask_q;

	// Persistent responder state.
	logic [1:0]        active_session_q;
	logic [1:0]        previous_session_q;
	phase_t            phase_q;
	logic [WORD_W-1:0] stored_seed_q;

	// Request register.
	logic              valid_s1;
	logic [1:0]        req_type_s1;
	logic [BYTE_W-1:0] req_length_s1;
	logic [BYTE_W-1:0] sub_function_s1;
	logic [WORD_W-1:0] key_in_s1;
	logic [WORD_W-1:0] random_seed_s1;

	// Response register.
	logic              out_valid_q;
	logic [1:0]        resp_service_q;
	logic              resp_positive_q;
	logic [1:0]        resp_code_q;
	logic [BYTE_W-1:0] resp_echo_q;
	logic [WORD_W-1:0] seed_out_q;

	// Decision logic results.
	logic              has_result;
	logic [1:0]        svc_d;
	logic              pos_d;
	logic [1:0]        code_d;
	logic [BYTE_W-1:0] echo_d;
	logic [1:0]        active_d;
	logic [1:0]        previous_d;
	phase_t            phase_d;
	logic [WORD_W-1:0] seed_d;

	logic [WORD_W-1:0] derived_key;
	logic              out_free;
	logic              advance;
	logic              in_take;

	assign cfg_ready = 1'b1;

	dssa_key_derive u_key (
		.seed (stored_seed_q),
		.mask (key_mask_q),
		.key  (derived_key)
	);

	// The response register can take a new beat when it is empty or is
	// being emptied in this cycle. A request that produces no response
	// leaves the request register regardless.
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && (!has_result || out_free);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_comb begin
		has_result = 1'b0;
		svc_d      = SVC_SESSION;
		pos_d      = 1'b0;
		code_d     = CODE_NONE;
		echo_d     = '0;
		active_d   = active_session_q;
		previous_d = previous_session_q;
		phase_d    = phase_q;
		seed_d     = stored_seed_q;
		unique case (req_type_s1)
			REQ_SESSION: begin
				has_result = 1'b1;
				svc_d      = SVC_SESSION;
				if (req_length_s1 != session_len_q) begin
					code_d = CODE_BAD_FORMAT;
				end else if (sub_function_s1 == {6'd0, SESS_DEFAULT}) begin
					active_d = SESS_DEFAULT;
					pos_d    = 1'b1;
					echo_d   = {6'd0, SESS_DEFAULT};
				end else if (sub_function_s1 == {6'd0, SESS_PROGRAM}) begin
					// Programming is only reachable while unlocked and from a non-default
					// session seen at the last tick; it then hands over to the
					// application instead of answering as a session change.
					if (previous_session_q != SESS_DEFAULT && phase_q == PH_UNLOCKED) begin
						svc_d = SVC_JUMP;
						pos_d = 1'b1;
					end else begin
						active_d = SESS_DEFAULT;
						code_d   = CODE_NOT_ACTIVE;
					end
				end else if (sub_function_s1 == {6'd0, SESS_EXTENDED}) begin
					active_d = SESS_EXTENDED;
					phase_d  = PH_ARMED;
					pos_d    = 1'b1;
					echo_d   = {6'd0, SESS_EXTENDED};
				end else begin
					code_d = CODE_UNSUPPORTED;
				end
			end
			REQ_SECURITY: begin
				has_result = 1'b1;
				svc_d      = SVC_SECURITY;
				if (sub_function_s1 == SUB_SEED_REQ && phase_q == PH_ARMED) begin
					phase_d = PH_SEED;
					seed_d  = random_seed_s1;
					pos_d   = 1'b1;
				end else if (sub_function_s1 == SUB_SEND_KEY && phase_q == PH_SEED &&
						derived_key == key_in_s1) begin
					phase_d = PH_UNLOCKED;
					pos_d   = 1'b1;
				end else begin
					code_d = CODE_UNSUPPORTED;
				end
			end
			REQ_TICK: begin
				previous_d = active_session_q;
			end
			default: begin
				// The unused request type is dropped without any effect.
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			session_len_q      <= LEN_RESET;
			key_mask_q         <= MASK_RESET;
			active_session_q   <= SESS_DEFAULT;
			previous_session_q <= SESS_DEFAULT;
			phase_q            <= PH_IDLE;
			stored_seed_q      <= '0;
			valid_s1           <= 1'b0;
			out_valid_q        <= 1'b0;
			resp_service_q     <= SVC_SESSION;
			resp_positive_q    <= 1'b0;
			resp_code_q        <= CODE_NONE;
			resp_echo_q        <= '0;
			seed_out_q         <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_SESSION_LEN) begin
					session_len_q <= cfg_data[BYTE_W-1:0];
				end else if (cfg_index == CFG_KEY_MASK) begin
					key_mask_q <= cfg_data;
				end
			end
			if (advance) begin
				active_session_q   <= active_d;
				previous_session_q <= previous_d;
				phase_q            <= phase_d;
				stored_seed_q      <= seed_d;
			end
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (out_free) begin
				out_valid_q <= advance && has_result;
			end
			if (out_free && advance && has_result) begin
				resp_service_q  <= svc_d;
				resp_positive_q <= pos_d;
				resp_code_q     <= code_d;
				resp_echo_q     <= echo_d;
				seed_out_q      <= seed_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			req_type_s1     <= req_type;
			req_length_s1   <= req_length;
			sub_function_s1 <= sub_function;
			key_in_s1       <= key_in;
			random_seed_s1  <= random_seed;
		end
	end

	assign out_valid         = out_valid_q;
	assign resp_service      = resp_service_q;
	assign resp_positive     = resp_positive_q;
	assign resp_code         = resp_code_q;
	assign resp_session_echo = resp_echo_q;
	assign seed_out          = seed_out_q;

`ifndef SYNTH
	a_unlock_from_seed: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_UNLOCKED && $past(phase_q) != PH_UNLOCKED) |->
		$past(phase_q) == PH_SEED)
		else $error("security unlocked without a seed having been sent");

	a_seed_with_phase: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(stored_seed_q) |-> phase_q == PH_SEED)
		else $error("stored seed changed outside a seed request");

	a_active_session: assert property (@(posedge clk) disable iff (!arst_n)
		active_session_q == SESS_DEFAULT || active_session_q == SESS_EXTENDED)
		else $error("active session holds an unexpected id");

	a_positive_no_code: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && resp_positive) |-> resp_code == CODE_NONE)
		else $error("positive response carries a negative code");

	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled while the pipeline has room");
`endif

endmodule
